// ----- src/vna_pkg.sv -----
package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int INDEX_BITS       = 10;
    localparam int NORM_BITS        = 16;
    localparam int SUM_BITS         = 32;
    localparam int COUNT_BITS       = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int VEC_BITS   = 32;
    localparam int SCALE_BITS = 30;
    localparam int SQ_BITS    = 64;
    localparam int LEN_BITS   = 31;
    localparam int QUO_BITS   = 16;
    localparam int NUM_BITS   = SCALE_BITS + NORMAL_FRAC_BITS;
    localparam logic [NORM_BITS-1:0] UNIT_ONE = NORM_BITS'(1) << NORMAL_FRAC_BITS;

    localparam logic signed [NORM_BITS-1:0] NORM_LIMIT_POS = 16'sd16384;
    localparam logic signed [NORM_BITS-1:0] NORM_LIMIT_NEG = -16'sd16384;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_WRITE    = 2'd1,
        OP_TRIANGLE = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef struct packed {
        op_t                           operation;
        logic [INDEX_BITS-1:0]         vertex_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
        logic [INDEX_BITS-1:0]         corner_a;
        logic [INDEX_BITS-1:0]         corner_b;
        logic [INDEX_BITS-1:0]         corner_c;
    } request_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        normal_index;
        logic signed [NORM_BITS-1:0]  normal_x;
        logic signed [NORM_BITS-1:0]  normal_y;
        logic signed [NORM_BITS-1:0]  normal_z;
    } result_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } pos_entry_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_x;
        logic signed [SUM_BITS-1:0] sum_y;
        logic signed [SUM_BITS-1:0] sum_z;
        logic [COUNT_BITS-1:0]      count;
    } acc_entry_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctrl_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_SQRT,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRI_A,
        ST_TRI_B,
        ST_TRI_C,
        ST_TRI_D,
        ST_NORM_E1,
        ST_NORM_E2,
        ST_CROSS,
        ST_NORM_F,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_DIV,
        ST_OUT
    } top_state_t;

endpackage

// ----- src/vna_ram.sv -----
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/vna_div.sv -----
module vna_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int Q_W   = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CW = $clog2(Q_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, low_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(num >> Q_W);
            low_reg <= num[Q_W-1:0];
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- src/vna_norm.sv -----
module vna_norm
    import vna_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  unit_ctrl_t                  ctrl_in,
    input  logic signed [VEC_BITS-1:0]  vec_x,
    input  logic signed [VEC_BITS-1:0]  vec_y,
    input  logic signed [VEC_BITS-1:0]  vec_z,
    output unit_ctrl_t                  ctrl_out,
    output logic signed [NORM_BITS-1:0] res_x,
    output logic signed [NORM_BITS-1:0] res_y,
    output logic signed [NORM_BITS-1:0] res_z
);

    norm_state_t st_reg, st_next;

    logic [VEC_BITS-1:0]       mag_reg [3];
    logic [2:0]                neg_reg;
    logic [SQ_BITS-1:0]        acc_reg;
    logic [2*SCALE_BITS-1:0]   prod_reg;
    logic [1:0]                k_reg;
    logic [SQ_BITS-1:0]        n_reg;
    logic [SQ_BITS-1:0]        root_reg;
    logic [SQ_BITS-1:0]        bit_reg;
    logic [1:0]                comp_reg;
    logic                      launched_reg;
    logic signed [NORM_BITS-1:0] out_reg [3];

    logic [VEC_BITS-1:0]  in_mag [3];
    logic                 in_zero;
    logic [VEC_BITS-1:0]  mx;
    logic [SQ_BITS-1:0]   trial;
    logic                 div_start;
    logic                 div_done;
    logic [QUO_BITS-1:0]  div_quo;
    logic [QUO_BITS-1:0]  clamped;
    logic [NUM_BITS-1:0]  div_num;

    assign in_mag[0] = vec_x[VEC_BITS-1] ? VEC_BITS'(-vec_x) : VEC_BITS'(vec_x);
    assign in_mag[1] = vec_y[VEC_BITS-1] ? VEC_BITS'(-vec_y) : VEC_BITS'(vec_y);
    assign in_mag[2] = vec_z[VEC_BITS-1] ? VEC_BITS'(-vec_z) : VEC_BITS'(vec_z);
    assign in_zero   = (vec_x == '0) && (vec_y == '0) && (vec_z == '0);

    always_comb begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx) begin
            mx = mag_reg[2];
        end
    end

    assign trial   = n_reg;
    assign div_num = {mag_reg[comp_reg][SCALE_BITS-1:0], NORMAL_FRAC_BITS'(0)};
    assign clamped = (div_quo > UNIT_ONE) ? UNIT_ONE : div_quo;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            N_IDLE: begin
                if (ctrl_in.start) begin
                    st_next = in_zero ? N_DONE : N_SHIFT;
                end
            end
            N_SHIFT: begin
                if (mx[VEC_BITS-1:SCALE_BITS] == '0 && mx[SCALE_BITS-1]) begin
                    st_next = N_SQUARE;
                end
            end
            N_SQUARE: begin
                if (k_reg == 2'd3) begin
                    st_next = N_SQRT;
                end
            end
            N_SQRT: begin
                if (bit_reg[0]) begin
                    st_next = N_DIV;
                end
            end
            N_DIV: begin
                if (div_done && comp_reg == 2'd2) begin
                    st_next = N_DONE;
                end
            end
            N_DONE: st_next = N_IDLE;
            default: st_next = N_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl_out.start = 1'b0;
        ctrl_out.done  = (st_reg == N_DONE);
        div_start      = (st_reg == N_DIV) && !launched_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= N_IDLE;
            launched_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (div_start) begin
                launched_reg <= 1'b1;
            end else if (div_done) begin
                launched_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            N_IDLE: begin
                if (ctrl_in.start) begin
                    mag_reg[0] <= in_mag[0];
                    mag_reg[1] <= in_mag[1];
                    mag_reg[2] <= in_mag[2];
                    neg_reg    <= {vec_z[VEC_BITS-1], vec_y[VEC_BITS-1], vec_x[VEC_BITS-1]};
                    k_reg      <= 2'd0;
                    comp_reg   <= 2'd0;
                    acc_reg    <= '0;
                    out_reg[0] <= '0;
                    out_reg[1] <= '0;
                    out_reg[2] <= '0;
                end
            end
            N_SHIFT: begin
                if (mx[VEC_BITS-1:SCALE_BITS] != '0) begin
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end else if (!mx[SCALE_BITS-1]) begin
                    mag_reg[0] <= mag_reg[0] << 1;
                    mag_reg[1] <= mag_reg[1] << 1;
                    mag_reg[2] <= mag_reg[2] << 1;
                end
            end
            N_SQUARE: begin
                if (k_reg != 2'd3) begin
                    prod_reg <= mag_reg[k_reg][SCALE_BITS-1:0] * mag_reg[k_reg][SCALE_BITS-1:0];
                end
                if (k_reg != 2'd0) begin
                    acc_reg <= acc_reg + SQ_BITS'(prod_reg);
                end
                if (k_reg == 2'd3) begin
                    n_reg    <= acc_reg + SQ_BITS'(prod_reg);
                    root_reg <= '0;
                    bit_reg  <= SQ_BITS'(1) << (SQ_BITS - 2);
                end
                k_reg <= k_reg + 2'd1;
            end
            N_SQRT: begin
                if (trial >= root_reg + bit_reg) begin
                    n_reg    <= n_reg - (root_reg + bit_reg);
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DIV: begin
                if (div_done) begin
                    out_reg[comp_reg] <= neg_reg[comp_reg] ? NORM_BITS'(-clamped)
                                                           : NORM_BITS'(clamped);
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            N_DONE: begin
                comp_reg <= 2'd0;
            end
            default: begin
                comp_reg <= 2'd0;
            end
        endcase
    end

    vna_div #(
        .NUM_W (NUM_BITS),
        .DEN_W (LEN_BITS),
        .Q_W   (QUO_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (root_reg[LEN_BITS-1:0]),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign res_x = out_reg[0];
    assign res_y = out_reg[1];
    assign res_z = out_reg[2];

endmodule

// ----- src/vertex_normal_averager.sv -----
// a triangle runs three passes of the normalizer (shift search, squares, 32-step root,
// three 16-step divides); a read with a nonzero count runs three 32-step divides;
// one request at a time: no new request is taken until the last one is finished, and
// a finished result waits in the output register
// reset: synchronous active low, then a clearing pass over every entry of the
// accumulator memory; a clear request runs the same pass
module vertex_normal_averager
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  request_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    top_state_t st_reg, st_next;

    request_t   req_reg;
    logic [AW-1:0] clr_addr_reg;
    pos_entry_t pa_reg, pb_reg;
    logic signed [EDGE_BITS-1:0] e1_reg [3];
    logic signed [EDGE_BITS-1:0] e2_reg [3];
    logic signed [NORM_BITS-1:0] n1_reg [3];
    logic signed [NORM_BITS-1:0] n2_reg [3];
    logic signed [NORM_BITS-1:0] face_reg [3];
    logic signed [VEC_BITS-1:0]  cross_reg [3];
    logic signed [2*NORM_BITS-1:0] prod_reg;
    logic [2:0] step_reg;
    logic [1:0] csel_reg;
    logic [1:0] comp_reg;
    logic       launched_reg;
    acc_entry_t acc_reg;
    logic signed [NORM_BITS-1:0] avg_reg [3];
    logic       out_valid_reg;
    result_t    out_reg;

    logic accept;
    logic pos_we;
    logic [AW-1:0] pos_waddr, pos_raddr;
    pos_entry_t pos_wdata, pos_rdata;
    logic acc_we;
    logic [AW-1:0] acc_waddr, acc_raddr;
    acc_entry_t acc_wdata, acc_rdata;
    logic [INDEX_BITS-1:0] corner;
    logic dup;
    logic req_in_range;
    logic tri_in_range;
    logic out_load;
    unit_ctrl_t norm_ctrl_in, norm_ctrl_out;
    logic signed [VEC_BITS-1:0] nv_x, nv_y, nv_z;
    logic signed [NORM_BITS-1:0] nr_x, nr_y, nr_z;
    logic norm_state;
    logic div_start, div_done;
    logic [SUM_BITS-1:0] div_quo;
    logic signed [SUM_BITS-1:0] rd_sum;
    logic [SUM_BITS-1:0] rd_mag;
    logic [SUM_BITS-1:0] rd_signed_quo;
    logic signed [NORM_BITS-1:0] opa, opb;
    logic [2:0] prev_step;
    logic [1:0] cidx;

    function automatic logic in_range(input logic [INDEX_BITS-1:0] idx);
        return 32'(idx) < MAX_VERTICES;
    endfunction

    assign accept       = s_valid && s_ready;
    assign req_in_range = in_range(s_data.vertex_index);
    assign tri_in_range = in_range(s_data.corner_a) && in_range(s_data.corner_b)
                          && in_range(s_data.corner_c);
    assign out_load     = (st_reg == ST_OUT) && (!out_valid_reg || m_ready);

    always_comb begin
        unique case (csel_reg)
            2'd0:    corner = req_reg.corner_a;
            2'd1:    corner = req_reg.corner_b;
            default: corner = req_reg.corner_c;
        endcase
    end

    assign dup = ((csel_reg == 2'd1) && (req_reg.corner_b == req_reg.corner_a))
              || ((csel_reg == 2'd2) && ((req_reg.corner_c == req_reg.corner_a)
                                      || (req_reg.corner_c == req_reg.corner_b)));

    assign norm_state = (st_reg == ST_NORM_E1) || (st_reg == ST_NORM_E2)
                        || (st_reg == ST_NORM_F);

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(MAX_VERTICES - 1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.operation)
                        OP_CLEAR:    st_next = ST_CLEAR;
                        OP_WRITE:    st_next = ST_IDLE;
                        OP_TRIANGLE: st_next = tri_in_range ? ST_TRI_A : ST_IDLE;
                        OP_READ:     st_next = req_in_range ? ST_RD_ADDR : ST_OUT;
                        default:     st_next = ST_IDLE;
                    endcase
                end
            end
            ST_TRI_A:   st_next = ST_TRI_B;
            ST_TRI_B:   st_next = ST_TRI_C;
            ST_TRI_C:   st_next = ST_TRI_D;
            ST_TRI_D:   st_next = ST_NORM_E1;
            ST_NORM_E1: st_next = norm_ctrl_out.done ? ST_NORM_E2 : ST_NORM_E1;
            ST_NORM_E2: st_next = norm_ctrl_out.done ? ST_CROSS : ST_NORM_E2;
            ST_CROSS:   st_next = (step_reg == 3'd6) ? ST_NORM_F : ST_CROSS;
            ST_NORM_F:  st_next = norm_ctrl_out.done ? ST_ACC_RD : ST_NORM_F;
            ST_ACC_RD: begin
                if (!dup) begin
                    st_next = ST_ACC_WR;
                end else if (csel_reg == 2'd2) begin
                    st_next = ST_IDLE;
                end
            end
            ST_ACC_WR:  st_next = (csel_reg == 2'd2) ? ST_IDLE : ST_ACC_RD;
            ST_RD_ADDR: st_next = ST_RD_DATA;
            ST_RD_DATA: st_next = (acc_rdata.count == '0) ? ST_OUT : ST_RD_DIV;
            ST_RD_DIV:  st_next = (div_done && comp_reg == 2'd2) ? ST_OUT : ST_RD_DIV;
            ST_OUT:     st_next = out_load ? ST_IDLE : ST_OUT;
            default:    st_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = (st_reg == ST_IDLE);
        pos_we    = accept && (s_data.operation == OP_WRITE) && req_in_range;
        pos_waddr = AW'(s_data.vertex_index);
        pos_wdata = '{x: s_data.coord_x, y: s_data.coord_y, z: s_data.coord_z};
        pos_raddr = AW'(req_reg.corner_a);
        acc_we    = 1'b0;
        acc_waddr = AW'(corner);
        acc_wdata = '0;
        acc_raddr = AW'(corner);
        unique case (st_reg)
            ST_TRI_B: pos_raddr = AW'(req_reg.corner_b);
            ST_TRI_C: pos_raddr = AW'(req_reg.corner_c);
            ST_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_addr_reg;
            end
            ST_ACC_WR: begin
                acc_we          = (acc_rdata.count != COUNT_MAX);
                acc_wdata.sum_x = acc_rdata.sum_x + SUM_BITS'(face_reg[0]);
                acc_wdata.sum_y = acc_rdata.sum_y + SUM_BITS'(face_reg[1]);
                acc_wdata.sum_z = acc_rdata.sum_z + SUM_BITS'(face_reg[2]);
                acc_wdata.count = acc_rdata.count + COUNT_BITS'(1);
            end
            ST_RD_ADDR: acc_raddr = AW'(req_reg.vertex_index);
            default: begin
                acc_we = 1'b0;
            end
        endcase
        norm_ctrl_in.start = norm_state && !launched_reg;
        norm_ctrl_in.done  = 1'b0;
        div_start          = (st_reg == ST_RD_DIV) && !launched_reg;
    end

    always_comb begin
        unique case (st_reg)
            ST_NORM_E1: begin
                nv_x = VEC_BITS'(e1_reg[0]);
                nv_y = VEC_BITS'(e1_reg[1]);
                nv_z = VEC_BITS'(e1_reg[2]);
            end
            ST_NORM_E2: begin
                nv_x = VEC_BITS'(e2_reg[0]);
                nv_y = VEC_BITS'(e2_reg[1]);
                nv_z = VEC_BITS'(e2_reg[2]);
            end
            default: begin
                nv_x = cross_reg[0];
                nv_y = cross_reg[1];
                nv_z = cross_reg[2];
            end
        endcase
    end

    // cross product operands, one partial product per step
    always_comb begin
        case (step_reg)
            3'd0:    begin opa = n1_reg[1]; opb = n2_reg[2]; end
            3'd1:    begin opa = n1_reg[2]; opb = n2_reg[1]; end
            3'd2:    begin opa = n1_reg[2]; opb = n2_reg[0]; end
            3'd3:    begin opa = n1_reg[0]; opb = n2_reg[2]; end
            3'd4:    begin opa = n1_reg[0]; opb = n2_reg[1]; end
            default: begin opa = n1_reg[1]; opb = n2_reg[0]; end
        endcase
    end

    assign prev_step = step_reg - 3'd1;
    assign cidx      = prev_step[2:1];

    always_comb begin
        case (comp_reg)
            2'd0:    rd_sum = acc_reg.sum_x;
            2'd1:    rd_sum = acc_reg.sum_y;
            default: rd_sum = acc_reg.sum_z;
        endcase
    end

    assign rd_mag        = rd_sum[SUM_BITS-1] ? SUM_BITS'(-rd_sum) : SUM_BITS'(rd_sum);
    assign rd_signed_quo = rd_sum[SUM_BITS-1] ? -div_quo : div_quo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_CLEAR;
            clr_addr_reg  <= '0;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end else begin
                clr_addr_reg <= '0;
            end
            if (norm_ctrl_in.start || div_start) begin
                launched_reg <= 1'b1;
            end else if (norm_ctrl_out.done || div_done) begin
                launched_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg    <= s_data;
            avg_reg[0] <= '0;
            avg_reg[1] <= '0;
            avg_reg[2] <= '0;
            csel_reg   <= 2'd0;
            comp_reg   <= 2'd0;
            step_reg   <= 3'd0;
        end
        unique case (st_reg)
            ST_TRI_B: pa_reg <= pos_rdata;
            ST_TRI_C: pb_reg <= pos_rdata;
            ST_TRI_D: begin
                e1_reg[0] <= EDGE_BITS'(pb_reg.x) - EDGE_BITS'(pa_reg.x);
                e1_reg[1] <= EDGE_BITS'(pb_reg.y) - EDGE_BITS'(pa_reg.y);
                e1_reg[2] <= EDGE_BITS'(pb_reg.z) - EDGE_BITS'(pa_reg.z);
                e2_reg[0] <= EDGE_BITS'(pos_rdata.x) - EDGE_BITS'(pb_reg.x);
                e2_reg[1] <= EDGE_BITS'(pos_rdata.y) - EDGE_BITS'(pb_reg.y);
                e2_reg[2] <= EDGE_BITS'(pos_rdata.z) - EDGE_BITS'(pb_reg.z);
                cross_reg[0] <= '0;
                cross_reg[1] <= '0;
                cross_reg[2] <= '0;
            end
            ST_NORM_E1: begin
                if (norm_ctrl_out.done) begin
                    n1_reg[0] <= nr_x;
                    n1_reg[1] <= nr_y;
                    n1_reg[2] <= nr_z;
                end
            end
            ST_NORM_E2: begin
                if (norm_ctrl_out.done) begin
                    n2_reg[0] <= nr_x;
                    n2_reg[1] <= nr_y;
                    n2_reg[2] <= nr_z;
                end
            end
            ST_CROSS: begin
                if (step_reg != 3'd6) begin
                    prod_reg <= opa * opb;
                end
                if (step_reg != 3'd0) begin
                    if (prev_step[0]) begin
                        cross_reg[cidx] <= cross_reg[cidx] - VEC_BITS'(prod_reg);
                    end else begin
                        cross_reg[cidx] <= cross_reg[cidx] + VEC_BITS'(prod_reg);
                    end
                end
                step_reg <= step_reg + 3'd1;
            end
            ST_NORM_F: begin
                if (norm_ctrl_out.done) begin
                    face_reg[0] <= nr_x;
                    face_reg[1] <= nr_y;
                    face_reg[2] <= nr_z;
                end
            end
            ST_ACC_RD: begin
                if (dup) begin
                    csel_reg <= csel_reg + 2'd1;
                end
            end
            ST_ACC_WR: csel_reg <= csel_reg + 2'd1;
            ST_RD_DATA: acc_reg <= acc_rdata;
            ST_RD_DIV: begin
                if (div_done) begin
                    avg_reg[comp_reg] <= NORM_BITS'(rd_signed_quo);
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            default: begin
                prod_reg <= prod_reg;
            end
        endcase
        if (out_load) begin
            out_reg.normal_index <= req_reg.vertex_index;
            out_reg.normal_x     <= avg_reg[0];
            out_reg.normal_y     <= avg_reg[1];
            out_reg.normal_z     <= avg_reg[2];
        end
    end

    vna_ram #(
        .WIDTH ($bits(pos_entry_t)),
        .DEPTH (MAX_VERTICES)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(
        .WIDTH ($bits(acc_entry_t)),
        .DEPTH (MAX_VERTICES)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    vna_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (norm_ctrl_in),
        .vec_x    (nv_x),
        .vec_y    (nv_y),
        .vec_z    (nv_z),
        .ctrl_out (norm_ctrl_out),
        .res_x    (nr_x),
        .res_y    (nr_y),
        .res_z    (nr_z)
    );

    vna_div #(
        .NUM_W (SUM_BITS),
        .DEN_W (COUNT_BITS),
        .Q_W   (SUM_BITS)
    ) u_rd_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (rd_mag),
        .den     (acc_reg.count),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- src/vna_checker.sv -----
module vna_checker
    import vna_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input request_t s_data,
    input logic     m_valid,
    input logic     m_ready,
    input result_t  m_data
);

    // result holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // clear request starts the sweep, no request taken next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_CLEAR |=> !s_ready)
        else $error("request taken during clear sweep");

    // averaged normal stays within one unit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.normal_x <= NORM_LIMIT_POS) && (m_data.normal_x >= NORM_LIMIT_NEG)
                 && (m_data.normal_y <= NORM_LIMIT_POS) && (m_data.normal_y >= NORM_LIMIT_NEG)
                 && (m_data.normal_z <= NORM_LIMIT_POS) && (m_data.normal_z >= NORM_LIMIT_NEG))
        else $error("normal out of range");

endmodule

bind vertex_normal_averager vna_checker u_vna_checker (.*);
